>>> sv/lis_pkg.sv
// Shared types, constants and helpers for the link impairment shaper.
`default_nettype none

package lis_pkg;

    // Field and register widths
    localparam int ELAPSED_W  = 48;
    localparam int BYTES_IN_W = 15;
    localparam int DELAY_W    = 33;
    localparam int WAIT_W     = 32;
    localparam int TX_W       = 37;
    localparam int REG_W      = 32;
    localparam int BW_W       = 40;
    localparam int CFG_W      = 64;
    localparam int IDX_W      = 3;
    localparam int RAND_W     = 64;

    // Shared divider geometry
    localparam int DVD_W      = 64;
    localparam int DVS_W      = 40;
    localparam int CNT_W      = 7;
    localparam int PER_BYTE_W = 23;

    localparam logic [RAND_W-1:0]     DEFAULT_SEED     = 64'h4d59_5df4_d0f3_3173;
    localparam logic [RAND_W-1:0]     ZERO_STATE_SUB   = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [PER_BYTE_W-1:0] BITS_PER_BYTE_US = 23'd8000000;

    // Divider step counts; dividends are left aligned in DVD_W bits
    localparam logic [CNT_W-1:0] OUTAGE_STEPS = CNT_W'(ELAPSED_W);
    localparam logic [CNT_W-1:0] JITTER_STEPS = CNT_W'(RAND_W);

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_BASE_DELAY = 3'd0,
        REG_JITTER     = 3'd1,
        REG_BANDWIDTH  = 3'd2,
        REG_PERIOD     = 3'd3,
        REG_LENGTH     = 3'd4,
        REG_SEED       = 3'd5
    } cfg_index_t;

    // Sequencer to divider control
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } div_req_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

    // One xorshift64 step (13, 7, 17); a zero state is replaced first
    function automatic logic [RAND_W-1:0] xorshift_next(input logic [RAND_W-1:0] s);
        logic [RAND_W-1:0] v;
        v = (s == '0) ? ZERO_STATE_SUB : s;
        v = v ^ (v << 13);
        v = v ^ (v >> 7);
        v = v ^ (v << 17);
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/lis_if.sv
// Valid/ready channel interfaces for shaper requests and results.
`default_nettype none

interface lis_req_if
    import lis_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [ELAPSED_W-1:0]  elapsed_us;
    logic [BYTES_IN_W-1:0] chunk_bytes;

    modport source (output valid, output op, output elapsed_us, output chunk_bytes,
                    input ready);
    modport sink   (input valid, input op, input elapsed_us, input chunk_bytes,
                    output ready);
endinterface

interface lis_rsp_if
    import lis_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DELAY_W-1:0] shaped_delay;
    logic [WAIT_W-1:0]  outage_wait_us;
    logic [TX_W-1:0]    pacing_time;

    modport source (output valid, output shaped_delay, output outage_wait_us,
                    output pacing_time, input ready);
    modport sink   (input valid, input shaped_delay, input outage_wait_us,
                    input pacing_time, output ready);
endinterface

`default_nettype wire

>>> sv/lis_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module lis_div
    import lis_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         ctrl,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_rsp_t              status,
    output logic [DVD_W-1:0]      quotient,
    output logic [DVS_W-1:0]      remainder
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] diff;

    // Trial subtract of the shifted partial remainder
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ctrl.steps;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[DVD_W-2:0], ~diff[DVS_W+1]};
            rem_next = diff[DVS_W+1] ? rem_sh[DVS_W-1:0] : diff[DVS_W-1:0];
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (cnt_reg == '0);
    assign quotient    = dvd_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

>>> sv/link_impairment_shaper.sv
// Link impairment shaper: jittered delay, outage wait and pacing time per event.
//
// Usage: events arrive on req (op 0 burst arrival, op 1 chunk send, elapsed
// time, chunk size); one transaction on rsp comes back for every event with
// the shaped delay, remaining outage wait and chunk transmit time.
// Registers are written through cfg_wr_en/cfg_index/cfg_data; the user must
// do so only while idle, which the block does not enforce. One event is
// worked at a time; req.ready is high only in the idle state. Both modulo
// operations and the pacing division run through one shared bit-serial
// divider, one bit per cycle. Between acceptance and rsp.valid the sequencer
// runs a 48-bit phase reduction when the outage period is non-zero, then a
// 64-bit draw reduction for a burst with non-zero jitter or a PROD_W-bit
// division (38 bits at the default size) for a chunk with non-zero bandwidth.
// req.ready rises together with rsp.valid when the result is registered.
// A held result does not block acceptance of the next event; only
// a second finished result waits for rsp.ready.
// Reset clears the configuration registers to zero, loads the generator with
// its default seed and empties the result register.
`default_nettype none

module link_impairment_shaper
    import lis_pkg::*;
#(
    parameter int MAX_CHUNK_BYTES = 16384
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    lis_req_if.sink               req,
    lis_rsp_if.source             rsp,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int BYTES_W = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int PROD_W  = BYTES_W + PER_BYTE_W;
    localparam int CLAMP_W = 17;
    localparam logic [CNT_W-1:0] TX_STEPS = CNT_W'(PROD_W);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_OUT      = 6'b000010,
        S_OUT_WAIT = 6'b000100,
        S_SECOND   = 6'b001000,
        S_SEC_WAIT = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    // Configuration and generator state
    logic [REG_W-1:0]  base_reg, jitter_reg, period_reg, length_reg;
    logic [BW_W-1:0]   bw_reg;
    logic [RAND_W-1:0] rand_reg;

    // Sequencer and working registers
    state_t              state_reg, state_next;
    logic                op_reg, op_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [REG_W-1:0]    len_reg, len_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic [TX_W-1:0]     tx_reg, tx_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [DELAY_W-1:0] out_delay_reg, out_delay_next;
    logic [WAIT_W-1:0]  out_wait_reg, out_wait_next;
    logic [TX_W-1:0]    out_tx_reg, out_tx_next;

    // Divider connection
    div_req_t          div_ctrl;
    div_rsp_t          div_status;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DVD_W-1:0]  div_quot;
    logic [DVS_W-1:0]  div_rem;

    logic                 accept;
    logic [CLAMP_W-1:0]   chunk_ext;
    logic [BYTES_W-1:0]   bytes_clamp;
    logic [REG_W-1:0]     phase;
    logic [DELAY_W+1:0]   jit_sum;

    lis_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_status),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign accept = req.valid && req.ready;

    // Chunk size saturates at the largest supported chunk
    assign chunk_ext   = CLAMP_W'(req.chunk_bytes);
    assign bytes_clamp = (chunk_ext > CLAMP_W'(MAX_CHUNK_BYTES))
                         ? BYTES_W'(MAX_CHUNK_BYTES) : BYTES_W'(chunk_ext);

    // base + r - jitter, negative means floor at zero
    assign phase   = div_rem[REG_W-1:0];
    assign jit_sum = (DELAY_W+2)'(base_reg) + (DELAY_W+2)'(div_rem[DELAY_W-1:0])
                     - (DELAY_W+2)'(jitter_reg);

    // Configuration writes and generator updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            jitter_reg <= '0;
            bw_reg     <= '0;
            period_reg <= '0;
            length_reg <= '0;
            rand_reg   <= DEFAULT_SEED;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_BASE_DELAY: base_reg   <= cfg_data[REG_W-1:0];
                REG_JITTER:     jitter_reg <= cfg_data[REG_W-1:0];
                REG_BANDWIDTH:  bw_reg     <= cfg_data[BW_W-1:0];
                REG_PERIOD:     period_reg <= cfg_data[REG_W-1:0];
                REG_LENGTH:     length_reg <= cfg_data[REG_W-1:0];
                REG_SEED:       rand_reg   <= (cfg_data != '0) ? cfg_data : DEFAULT_SEED;
                default:        ;
            endcase
        end
        else if (accept && !req.op && jitter_reg != '0)
        begin
            rand_reg <= xorshift_next(rand_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        elapsed_next   = elapsed_reg;
        bytes_next     = bytes_reg;
        prod_next      = prod_reg;
        len_next       = len_reg;
        delay_next     = delay_reg;
        wait_next      = wait_reg;
        tx_next        = tx_reg;
        out_valid_next = out_valid_reg;
        out_delay_next = out_delay_reg;
        out_wait_next  = out_wait_reg;
        out_tx_next    = out_tx_reg;
        div_ctrl       = '0;
        div_dividend   = '0;
        div_divisor    = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = req.op;
                    elapsed_next = req.elapsed_us;
                    bytes_next   = bytes_clamp;
                    delay_next   = '0;
                    wait_next    = '0;
                    tx_next      = '0;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                prod_next = PROD_W'(PROD_W'(bytes_reg) * PROD_W'(BITS_PER_BYTE_US));
                len_next  = (length_reg > period_reg) ? period_reg : length_reg;
                if (period_reg == '0)
                begin
                    state_next = S_SECOND;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = OUTAGE_STEPS;
                    div_dividend   = {elapsed_reg, {(DVD_W-ELAPSED_W){1'b0}}};
                    div_divisor    = DVS_W'(period_reg);
                    state_next     = S_OUT_WAIT;
                end
            end
            S_OUT_WAIT:
            begin
                if (div_status.done)
                begin
                    wait_next  = (phase < len_reg) ? (len_reg - phase) : '0;
                    state_next = S_SECOND;
                end
            end
            S_SECOND:
            begin
                if (!op_reg)
                begin
                    if (jitter_reg == '0)
                    begin
                        delay_next = DELAY_W'(base_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_ctrl.start = 1'b1;
                        div_ctrl.steps = JITTER_STEPS;
                        div_dividend   = rand_reg;
                        div_divisor    = DVS_W'({jitter_reg, 1'b1});
                        state_next     = S_SEC_WAIT;
                    end
                end
                else if (bw_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = TX_STEPS;
                    div_dividend   = {prod_reg, {(DVD_W-PROD_W){1'b0}}};
                    div_divisor    = bw_reg;
                    state_next     = S_SEC_WAIT;
                end
            end
            S_SEC_WAIT:
            begin
                if (div_status.done)
                begin
                    if (!op_reg)
                    begin
                        delay_next = jit_sum[DELAY_W+1] ? '0 : jit_sum[DELAY_W-1:0];
                    end
                    else
                    begin
                        tx_next = (|div_quot[DVD_W-1:TX_W]) ? '1 : div_quot[TX_W-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_delay_next = delay_reg;
                    out_wait_next  = wait_reg;
                    out_tx_next    = tx_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        elapsed_reg   <= elapsed_next;
        bytes_reg     <= bytes_next;
        prod_reg      <= prod_next;
        len_reg       <= len_next;
        delay_reg     <= delay_next;
        wait_reg      <= wait_next;
        tx_reg        <= tx_next;
        out_delay_reg <= out_delay_next;
        out_wait_reg  <= out_wait_next;
        out_tx_reg    <= out_tx_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.shaped_delay   = out_delay_reg;
    assign rsp.outage_wait_us = out_wait_reg;
    assign rsp.pacing_time    = out_tx_reg;

`ifndef SYNTHESIS
    // Divider is never running while an event may be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !div_status.busy)
        else $error("divider busy while idle");

    // A divider completion is only seen in a waiting state
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_OUT_WAIT || state_reg == S_SEC_WAIT))
        else $error("divider completion outside a wait state");

    // An accepted event closes the input until its work finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("input still open after acceptance");

    // A result never carries both a delay and a transmit time
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.shaped_delay == '0 || rsp.pacing_time == '0))
        else $error("delay and transmit time both set");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for link_impairment_shaper: directed table, then randomised phases.
module tb
    import lis_pkg::*;
;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 9;
    localparam int TIMEOUT_CYCLES   = 1000000;
    localparam int MAX_CHUNK_BYTES  = 16384;
    localparam int NUM_PHASES       = 8;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 150;
    localparam int SETTLE_CYCLES    = 4;
    localparam int MISMATCH_REPORTS = 10;

    // Request operation codes
    localparam logic OP_BURST = 1'b0;
    localparam logic OP_CHUNK = 1'b1;

    // Register indexes with no register behind them
    localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;

    localparam logic [63:0] TX_CEILING = (64'd1 << TX_W) - 64'd1;
    localparam logic [63:0] REG_MAX    = 64'hFFFF_FFFF;
    localparam logic [63:0] BW_MAX     = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic                  op;
        logic [ELAPSED_W-1:0]  elapsed_us;
        logic [BYTES_IN_W-1:0] chunk_bytes;
    } shaper_event_t;

    typedef struct packed {
        logic [DELAY_W-1:0] shaped_delay;
        logic [WAIT_W-1:0]  outage_wait_us;
        logic [TX_W-1:0]    pacing_time;
    } shaper_result_t;

    typedef enum {ROW_WRITE, ROW_EVENT} row_kind_t;

    typedef struct {
        row_kind_t      kind;
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        shaper_event_t  ev;
        bit             known;
        shaper_result_t res;
    } plan_row_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_COMB, RX_SPARSE} rx_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    lis_req_if req_ch ();
    lis_rsp_if rsp_ch ();

    link_impairment_shaper #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copy of the register file and generator state
    logic [REG_W-1:0]  base_q      = '0;
    logic [REG_W-1:0]  jitter_q    = '0;
    logic [BW_W-1:0]   bandwidth_q = '0;
    logic [REG_W-1:0]  period_q    = '0;
    logic [REG_W-1:0]  length_q    = '0;
    logic [RAND_W-1:0] gen_state   = DEFAULT_SEED;

    shaper_result_t due_results[$];

    int mismatch_count  = 0;
    int results_checked = 0;
    int bursts_sent     = 0;
    int chunks_sent     = 0;
    int reg_writes      = 0;
    int burst_left      = 0;
    int no_gap_left     = 0;
    int hold_ticket     = 0;

    // Shaped delay, outage wait and pacing time for one event; advances the generator
    function automatic shaper_result_t shape_event(shaper_event_t ev);
        shaper_result_t    r;
        logic [RAND_W-1:0] s;
        logic [63:0]       span, pick, cut, delay, len, phase, bytes, tx;
        r = '0;
        if (ev.op == OP_BURST)
        begin
            delay = 64'(base_q);
            if (jitter_q != '0)
            begin
                s = (gen_state == '0) ? ZERO_STATE_SUB : gen_state;
                s = s ^ (s << 13);
                s = s ^ (s >> 7);
                s = s ^ (s << 17);
                gen_state = s;
                span = 64'(jitter_q) * 64'd2 + 64'd1;
                pick = s % span;
                if (pick <= 64'(jitter_q))
                begin
                    cut = 64'(jitter_q) - pick;
                    delay = (64'(base_q) > cut) ? 64'(base_q) - cut : 64'd0;
                end
                else
                    delay = 64'(base_q) + (pick - 64'(jitter_q));
            end
            r.shaped_delay = delay[DELAY_W-1:0];
        end
        else if (bandwidth_q != '0)
        begin
            bytes = (ev.chunk_bytes > MAX_CHUNK_BYTES) ? 64'(MAX_CHUNK_BYTES)
                                                       : 64'(ev.chunk_bytes);
            tx = bytes * 64'(BITS_PER_BYTE_US) / 64'(bandwidth_q);
            r.pacing_time = (tx > TX_CEILING) ? '1 : tx[TX_W-1:0];
        end
        // outage length clamped to the period
        if (period_q != '0)
        begin
            len = (length_q > period_q) ? 64'(period_q) : 64'(length_q);
            phase = 64'(ev.elapsed_us) % 64'(period_q);
            r.outage_wait_us = (phase < len) ? WAIT_W'(len - phase) : '0;
        end
        return r;
    endfunction

    function automatic void apply_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_BASE_DELAY: base_q      = data[REG_W-1:0];
            REG_JITTER:     jitter_q    = data[REG_W-1:0];
            REG_BANDWIDTH:  bandwidth_q = data[BW_W-1:0];
            REG_PERIOD:     period_q    = data[REG_W-1:0];
            REG_LENGTH:     length_q    = data[REG_W-1:0];
            REG_SEED:       gen_state   = (data != '0) ? data : DEFAULT_SEED;
            default: ;
        endcase
    endfunction

    // Directed table rows
    function automatic plan_row_t write_row(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        plan_row_t row;
        row = '{kind: ROW_WRITE, idx: idx, data: data, ev: '0, known: 1'b0, res: '0};
        return row;
    endfunction

    function automatic plan_row_t event_row(logic op, logic [63:0] elapsed, int bytes);
        plan_row_t row;
        row = '{kind: ROW_EVENT, idx: '0, data: '0, ev: '0, known: 1'b0, res: '0};
        row.ev.op          = op;
        row.ev.elapsed_us  = elapsed[ELAPSED_W-1:0];
        row.ev.chunk_bytes = bytes[BYTES_IN_W-1:0];
        return row;
    endfunction

    function automatic plan_row_t known_row(logic op, logic [63:0] elapsed, int bytes,
                                            logic [63:0] delay, logic [63:0] owait,
                                            logic [63:0] tx);
        plan_row_t row;
        row = event_row(op, elapsed, bytes);
        row.known = 1'b1;
        row.res.shaped_delay   = delay[DELAY_W-1:0];
        row.res.outage_wait_us = owait[WAIT_W-1:0];
        row.res.pacing_time    = tx[TX_W-1:0];
        return row;
    endfunction

    // Register value for a random phase; phase 0 takes the maxima, phase 1 all zero
    function automatic logic [CFG_W-1:0] phase_value(int phase, cfg_index_t idx);
        logic [CFG_W-1:0] v, junk;
        junk = {$urandom, $urandom};
        if (phase == 0)
            return (idx == REG_SEED) ? '1 : (idx == REG_BANDWIDTH) ? BW_MAX : REG_MAX;
        if (phase == 1)
            return '0;
        case (idx)
            REG_SEED:
                return ($urandom_range(0, 5) == 0) ? '0 : junk;
            REG_BANDWIDTH:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 64'd1;
                    1:       v = junk & BW_MAX;
                    2:       v = BW_MAX;
                    3:       v = '0;
                    default: v = 64'($urandom_range(1000, 100000000));
                endcase
                // stray bits above the register must be dropped
                if ($urandom_range(0, 3) == 0)
                    v = v | (junk & ~BW_MAX);
            end
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = junk & REG_MAX;
                    2:       v = REG_MAX;
                    default: v = 64'($urandom_range(1, 1500));
                endcase
                if ($urandom_range(0, 3) == 0)
                    v = v | (junk & ~REG_MAX);
            end
        endcase
        return v;
    endfunction

    function automatic shaper_event_t random_event();
        shaper_event_t ev;
        logic [63:0]   wide;
        ev.op = ($urandom_range(0, 1) == 1) ? OP_CHUNK : OP_BURST;
        case ($urandom_range(0, 6))
            0:       wide = 64'($urandom_range(0, 3000));
            1, 2:    wide = 64'(period_q) * 64'($urandom_range(0, 50000))
                            + 64'($urandom_range(0, 1200));
            // straddle the end of the outage window
            3:       wide = 64'(period_q) * 64'($urandom_range(0, 50000))
                            + 64'(length_q) + 64'($urandom_range(0, 2)) - 64'd1;
            4:       wide = '1;
            default: wide = {$urandom, $urandom};
        endcase
        ev.elapsed_us = wide[ELAPSED_W-1:0];
        case ($urandom_range(0, 7))
            0:       ev.chunk_bytes = '0;
            1:       ev.chunk_bytes = BYTES_IN_W'(MAX_CHUNK_BYTES);
            2:       ev.chunk_bytes = BYTES_IN_W'($urandom_range(MAX_CHUNK_BYTES + 1, 32767));
            default: ev.chunk_bytes = BYTES_IN_W'($urandom_range(1, MAX_CHUNK_BYTES));
        endcase
        return ev;
    endfunction

    // Sender idling: bursts of transactions separated by random gaps
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (no_gap_left > 0)
            no_gap_left--;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_event(shaper_event_t ev, bit known, shaper_result_t typed);
        shaper_result_t predicted;
        req_ch.valid       <= 1'b1;
        req_ch.op          <= ev.op;
        req_ch.elapsed_us  <= ev.elapsed_us;
        req_ch.chunk_bytes <= ev.chunk_bytes;
        do
            @(posedge clk);
        while (!req_ch.ready);
        // always run the predictor so the generator stays in step
        predicted = shape_event(ev);
        due_results.push_back(known ? typed : predicted);
        if (ev.op == OP_BURST)
            bursts_sent++;
        else
            chunks_sent++;
        pace_sender();
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        reg_writes++;
    endtask

    // Main stimulus
    initial
    begin : stimulus
        plan_row_t  plan[$];
        cfg_index_t reg_order[6];
        bit         writing;
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.op          <= OP_BURST;
        req_ch.elapsed_us  <= '0;
        req_ch.chunk_bytes <= '0;
        reg_order = '{REG_BASE_DELAY, REG_JITTER, REG_BANDWIDTH,
                      REG_PERIOD, REG_LENGTH, REG_SEED};

        // after reset: everything disabled
        plan.push_back(known_row(OP_BURST, 64'd0, 0, 0, 0, 0));
        plan.push_back(known_row(OP_CHUNK, 64'hFFFF_FFFF_FFFF, 32767, 0, 0, 0));
        // fixed delay, 8 Mbit/s, 30 us outage every 100 us
        plan.push_back(write_row(REG_BASE_DELAY, 64'd1000));
        plan.push_back(write_row(REG_JITTER, 64'd0));
        plan.push_back(write_row(REG_BANDWIDTH, 64'd8000000));
        plan.push_back(write_row(REG_PERIOD, 64'd100));
        plan.push_back(write_row(REG_LENGTH, 64'd30));
        plan.push_back(known_row(OP_BURST, 64'd0, 0, 1000, 30, 0));
        plan.push_back(known_row(OP_CHUNK, 64'd129, 1000, 0, 1, 1000));
        plan.push_back(known_row(OP_CHUNK, 64'd130, MAX_CHUNK_BYTES, 0, 0, 16384));
        plan.push_back(known_row(OP_CHUNK, 64'd250, 32767, 0, 0, 16384));
        // outage longer than its period
        plan.push_back(write_row(REG_LENGTH, 64'd500));
        plan.push_back(known_row(OP_BURST, 64'd205, 0, 1000, 95, 0));
        // jitter on, zero seed, bandwidth, period and length at their maximum
        plan.push_back(write_row(REG_JITTER, 64'd100));
        plan.push_back(write_row(REG_SEED, 64'd0));
        plan.push_back(write_row(REG_BANDWIDTH, BW_MAX));
        plan.push_back(write_row(REG_PERIOD, REG_MAX));
        plan.push_back(write_row(REG_LENGTH, REG_MAX));
        plan.push_back(event_row(OP_BURST, 64'd0, 0));
        plan.push_back(event_row(OP_BURST, 64'hFFFF_FFFF_FFFF, 0));
        plan.push_back(event_row(OP_CHUNK, 64'hFFFF_FFFE, MAX_CHUNK_BYTES));
        plan.push_back(write_row(REG_BASE_DELAY, REG_MAX));
        plan.push_back(write_row(REG_JITTER, REG_MAX));
        plan.push_back(write_row(REG_SEED, '1));
        plan.push_back(event_row(OP_BURST, 64'h1234_5678_9ABC, 0));
        plan.push_back(event_row(OP_BURST, 64'h8000_0000_0000, 0));
        plan.push_back(event_row(OP_BURST, 64'd1, 0));
        // zero base with jitter floors at zero; slowest pacing
        plan.push_back(write_row(REG_BASE_DELAY, 64'd0));
        plan.push_back(write_row(REG_JITTER, 64'd5));
        plan.push_back(write_row(REG_SEED, 64'd1));
        plan.push_back(write_row(REG_BANDWIDTH, 64'd1));
        plan.push_back(write_row(REG_PERIOD, 64'd1));
        plan.push_back(write_row(REG_LENGTH, 64'd1));
        plan.push_back(event_row(OP_BURST, 64'd7, 0));
        plan.push_back(event_row(OP_BURST, 64'd8, 0));
        plan.push_back(event_row(OP_BURST, 64'd9, 0));
        plan.push_back(known_row(OP_CHUNK, 64'd3, MAX_CHUNK_BYTES, 0, 1, 64'd131072000000));
        plan.push_back(known_row(OP_CHUNK, 64'd0, 0, 0, 1, 0));
        // writes to unused indexes change nothing
        plan.push_back(write_row(IDX_SPARE_A, '1));
        plan.push_back(write_row(IDX_SPARE_B, '1));
        plan.push_back(known_row(OP_CHUNK, 64'd0, 1, 0, 1, 64'd8000000));
        // stray upper bits only: period reads back as zero
        plan.push_back(write_row(REG_PERIOD, 64'hABCD_0000_0000_0000));
        plan.push_back(known_row(OP_CHUNK, 64'd5, 2, 0, 0, 64'd16000000));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        writing = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (!writing)
                    settle_block();
                write_register(plan[i].idx, plan[i].data);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                    cfg_wr_en <= 1'b0;
                writing = 1'b0;
                offer_event(plan[i].ev, plan[i].known, plan[i].res);
            end
        end

        // random phases, each under a fresh register setting
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle_block();
            foreach (reg_order[r])
                write_register(reg_order[r], phase_value(phase, reg_order[r]));
            cfg_wr_en <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long receiver hold while the sender keeps offering
                if (phase == 3 && n == 20)
                begin
                    hold_ticket <= hold_ticket + 1;
                    no_gap_left = 60;
                end
                if (phase == 5 && n == 50)
                    settle_block();
                offer_event(random_event(), 1'b0, '0);
            end
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("tb: %0d bursts and %0d chunks over %0d register writes, %0d results checked",
                 bursts_sent, chunks_sent, reg_writes, results_checked);
        $display("tb: %0d mismatches, %0d results still outstanding",
                 mismatch_count, due_results.size());
        if (mismatch_count == 0 && due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: changing stall patterns plus an occasional long hold
    initial
    begin : receiver
        int       hold_left;
        int       seen_ticket;
        int       mode_left;
        int       tick;
        rx_mode_t mode;
        hold_left   = 0;
        seen_ticket = 0;
        mode_left   = 0;
        tick        = 0;
        mode        = RX_ALWAYS;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_ticket != seen_ticket)
            begin
                seen_ticket = hold_ticket;
                hold_left = LONG_HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 150);
                end
                else
                    mode_left--;
                tick++;
                case (mode)
                    RX_ALWAYS: rsp_ch.ready <= 1'b1;
                    RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 99) < 60);
                    RX_COMB:   rsp_ch.ready <= ((tick % 5) < 2);
                    default:   rsp_ch.ready <= ((tick % 13) == 0);
                endcase
            end
        end
    end

    // Result checker: each transaction against the oldest prediction
    always @(posedge clk)
    begin : result_check
        shaper_result_t got;
        shaper_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.shaped_delay   = rsp_ch.shaped_delay;
            got.outage_wait_us = rsp_ch.outage_wait_us;
            got.pacing_time    = rsp_ch.pacing_time;
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_REPORTS)
                    $display("tb: unexpected transaction delay %0h wait %0h tx %0h",
                             got.shaped_delay, got.outage_wait_us, got.pacing_time);
            end
            else
            begin
                want = due_results.pop_front();
                results_checked++;
                if (got.shaped_delay !== want.shaped_delay
                    || got.outage_wait_us !== want.outage_wait_us
                    || got.pacing_time !== want.pacing_time)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_REPORTS)
                        $display({"tb: result %0d mismatch: delay %0h/%0h",
                                  " wait %0h/%0h tx %0h/%0h (expected/actual)"},
                                 results_checked, want.shaped_delay, got.shaped_delay,
                                 want.outage_wait_us, got.outage_wait_us,
                                 want.pacing_time, got.pacing_time);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb: failure");
        $finish;
    end

endmodule

>>> link_impairment_shaper.f
sv/lis_pkg.sv
sv/lis_if.sv
sv/lis_div.sv
sv/link_impairment_shaper.sv
test/tb.sv
